// ----- design/rtki_pkg.sv -----
// Shared types and constants for the ranked top-k insertion table.
package rtki_pkg;

    // Table geometry
    localparam int DEPTH    = 8;
    localparam int TAG_BITS = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int SCORE_W  = 32;
    localparam int TIME_W   = 32;
    localparam int ETAG_W   = 16;
    localparam int RIDX_W   = 3;
    localparam int RANK_W   = 4;

    // Operation codes; code 3 is a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SCORE_W-1:0] ins_score;
        logic [TIME_W-1:0]  new_time;
        logic [ETAG_W-1:0]  entry_tag;
        logic [RIDX_W-1:0]  read_index;
    } in_word_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [SCORE_W-1:0] read_score;
        logic [TIME_W-1:0]  read_time;
        logic [ETAG_W-1:0]  read_tag;
        logic [SCORE_W-1:0] best_score;
    } out_word_t;

    // One stored table slot
    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [TIME_W-1:0]   etime;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    // Sequencer to table controls
    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_entry;
        logic [IDX_W-1:0] rd_addr;
    } tbl_ctrl_t;

endpackage

// ----- design/rtki_cmp.sv -----
// Shared rank comparator: does the candidate rank strictly above a slot.
module rtki_cmp (
    input  rtki_pkg::entry_t cand,
    input  rtki_pkg::entry_t slot,
    output logic             beats
);
    import rtki_pkg::*;

    // Higher score wins, smaller time breaks a tie
    always_comb
    begin
        beats = (cand.score > slot.score) ||
                ((cand.score == slot.score) && (cand.etime < slot.etime));
    end

endmodule

// ----- design/rtki_table.sv -----
// Slot storage for the ranked table: one read port, one write port, bulk clear.
module rtki_table (
    input  logic               clk,
    input  logic               rst_n,
    input  rtki_pkg::tbl_ctrl_t ctrl,
    output rtki_pkg::entry_t   rd_entry,
    output logic [31:0]        head_score
);
    import rtki_pkg::*;

    entry_t slots_reg [DEPTH];

    // Clear all slots or write one slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else if (ctrl.wr_en)
        begin
            slots_reg[ctrl.wr_addr] <= ctrl.wr_entry;
        end
    end

    // Read port and head slot
    assign rd_entry   = slots_reg[ctrl.rd_addr];
    assign head_score = slots_reg[0].score;

endmodule

// ----- design/rtki_ctrl.sv -----
// Sequencer: accepts a word, walks the table bottom-up for inserts, registers the result.
module rtki_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rtki_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rtki_pkg::out_word_t  out_word,
    output rtki_pkg::tbl_ctrl_t  tbl,
    output rtki_pkg::entry_t     cand,
    input  rtki_pkg::entry_t     rd_entry,
    input  logic [31:0]          head_score,
    input  logic                 beats
);
    import rtki_pkg::*;

    state_t            state_reg, state_next;
    in_word_t          item_reg, item_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    out_word_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;
    logic              read_in_range;
    logic              out_free;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        k_reg        <= k_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    // Candidate entry built from the held word
    always_comb
    begin
        cand.score = item_reg.ins_score;
        cand.etime = item_reg.new_time;
        cand.tag   = TAG_BITS'(item_reg.entry_tag);
    end

    assign read_in_range = (int'(item_reg.read_index) < DEPTH);
    assign out_free      = !out_valid_reg || out_ready;

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        tbl.clear      = 1'b0;
        tbl.wr_en      = 1'b0;
        tbl.wr_addr    = k_reg;
        tbl.wr_entry   = cand;
        tbl.rd_addr    = k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_word;
                    k_next    = IDX_W'(DEPTH - 1);
                    res_next  = '0;
                    if (in_word.cmd == CMD_INSERT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                // Read one slot, or clear the table; other codes do nothing
                tbl.rd_addr = IDX_W'(item_reg.read_index);
                if (item_reg.cmd == CMD_READ && read_in_range)
                begin
                    res_next.read_score = rd_entry.score;
                    res_next.read_time  = rd_entry.etime;
                    res_next.read_tag   = ETAG_W'(rd_entry.tag);
                end
                if (item_reg.cmd == CMD_CLEAR)
                begin
                    tbl.clear = 1'b1;
                end
                state_next = ST_RESP;
            end

            ST_SCAN:
            begin
                // Compare against slot k; shift it down or drop the candidate in below it
                if (beats)
                begin
                    if (k_reg != IDX_W'(DEPTH - 1))
                    begin
                        tbl.wr_en    = 1'b1;
                        tbl.wr_addr  = k_reg + IDX_W'(1);
                        tbl.wr_entry = rd_entry;
                    end
                    if (k_reg == '0)
                    begin
                        // Head beaten: the shift lands now, slot 0 is written in RESP
                        res_next.rank = '0;
                        state_next    = ST_RESP;
                    end
                    else
                    begin
                        k_next = k_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    if (k_reg == IDX_W'(DEPTH - 1))
                    begin
                        res_next.rank = RANK_W'(DEPTH);
                    end
                    else
                    begin
                        tbl.wr_en     = 1'b1;
                        tbl.wr_addr   = k_reg + IDX_W'(1);
                        tbl.wr_entry  = cand;
                        res_next.rank = RANK_W'(k_reg) + RANK_W'(1);
                    end
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                // Finish a head insert while k still points at slot 0,
                // then hand the word to the output register
                if (item_reg.cmd == CMD_INSERT && res_reg.rank == '0 && k_reg == '0)
                begin
                    tbl.wr_en    = 1'b1;
                    tbl.wr_addr  = '0;
                    tbl.wr_entry = cand;
                    k_next       = IDX_W'(1);
                end
                else if (out_free)
                begin
                    out_word_next            = res_reg;
                    out_word_next.best_score = head_score;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- design/ranked_topk_table_insert_unit.sv -----
// Top level of the ranked top-k insertion table.
//
//   channel | signals                          | word
//   --------+----------------------------------+-----------------------
//   input   | in_valid / in_ready / in_word    | rtki_pkg::in_word_t
//   output  | out_valid / out_ready / out_word | rtki_pkg::out_word_t
//
// An insert walks the table from the last slot upward through one shared
// comparator, one slot per cycle, shifting each beaten slot down as it goes.
// The result step writes slot 0 first when the entry lands there, then loads
// the output register, and the idle state takes the next word.
// Read, clear and the unused code pass through the execute and result steps
// before the next accept. Reset zeroes every slot at once. A result waiting in
// the output register does not block the next accept; the sequencer stalls
// only at its result step until that register frees.
module ranked_topk_table_insert_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rtki_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output rtki_pkg::out_word_t out_word
);
    import rtki_pkg::*;

    tbl_ctrl_t    tbl;
    entry_t       cand;
    entry_t       rd_entry;
    logic [31:0]  head_score;
    logic         beats;

    rtki_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .tbl        (tbl),
        .cand       (cand),
        .rd_entry   (rd_entry),
        .head_score (head_score),
        .beats      (beats)
    );

    rtki_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (tbl),
        .rd_entry   (rd_entry),
        .head_score (head_score)
    );

    rtki_cmp u_cmp (
        .cand  (cand),
        .slot  (rd_entry),
        .beats (beats)
    );

endmodule
